@@ rtl/core/smt_pkg.sv @@
// Package for the set membership table: sizes, action codes and the cell control struct.
// Depends on nothing; every other file of the block takes names from here by scope.
package smt_pkg;

   localparam int CAPACITY     = 64;
   localparam int ELEMENT_BITS = 32;
   localparam int ACTION_BITS  = 2;
   localparam int INPUT_BITS   = 32;
   localparam int KEY_BITS     = (ELEMENT_BITS < INPUT_BITS) ? ELEMENT_BITS : INPUT_BITS;
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic compare_en;
      logic append_en;
      logic delete_en;
   } cell_ctrl_type;

endpackage

@@ rtl/core/smt_if.sv @@
// Handshake interfaces for the request and response channels of the set membership table.
// Depends on smt_pkg for field widths.
interface smt_req_if;
   logic                            valid;
   logic                            ready;
   logic [smt_pkg::ACTION_BITS-1:0] action;
   logic [smt_pkg::INPUT_BITS-1:0]  element;

   modport source (output valid, output action, output element, input ready);
   modport sink   (input valid, input action, input element, output ready);
endinterface

interface smt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           was_member;
   logic [smt_pkg::COUNT_BITS-1:0] member_count;
   logic                           is_empty;
   logic                           is_full;
   logic                           insert_dropped;

   modport source (output valid, output was_member, output member_count, output is_empty,
                   output is_full, output insert_dropped, input ready);
   modport sink   (input valid, input was_member, input member_count, input is_empty,
                   input is_full, input insert_dropped, output ready);
endinterface

@@ rtl/core/smt_cell.sv @@
// One storage cell of the set table: holds an entry, compares it and shifts it.
// Depends on smt_pkg for widths and the control struct.
module smt_cell (
   input  logic                            clock,
   input  smt_pkg::cell_ctrl_type          ctrl,
   input  logic [smt_pkg::COUNT_BITS-1:0]  index,
   input  logic [smt_pkg::COUNT_BITS-1:0]  count,
   input  logic [smt_pkg::KEY_BITS-1:0]    key,
   input  logic [smt_pkg::KEY_BITS-1:0]    upper_entry,
   input  logic                            shift_in,
   output logic                            shift_out,
   output logic                            match,
   output logic [smt_pkg::KEY_BITS-1:0]    entry
);

   logic [smt_pkg::KEY_BITS-1:0] entry_ff, entry_in;
   logic                         match_ff, match_in;
   logic                         active;

   assign active = index < count;

   always_comb begin
      match_in = match_ff;
      if (ctrl.compare_en) begin
         match_in = active && (entry_ff == key);
      end
   end

   // A cell at or above the deleted entry takes the value of its upper neighbour.
   assign shift_out = shift_in | match_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.delete_en && shift_out) begin
         entry_in = upper_entry;
      end else if (ctrl.append_en && (index == count)) begin
         entry_in = key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign match = match_ff;
   assign entry = entry_ff;

endmodule

@@ rtl/core/smt_cell_chain.sv @@
// Row of storage cells for the set table, linked by shift data and the deletion flag.
// Depends on smt_pkg and smt_cell.
module smt_cell_chain (
   input  logic                           clock,
   input  smt_pkg::cell_ctrl_type         ctrl,
   input  logic [smt_pkg::COUNT_BITS-1:0] count,
   input  logic [smt_pkg::KEY_BITS-1:0]   key,
   output logic                           member,
   output logic [smt_pkg::CAPACITY-1:0]   match_vec
);

   logic [smt_pkg::KEY_BITS-1:0] entries [smt_pkg::CAPACITY];
   logic [smt_pkg::CAPACITY:0]   shift_chain;

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < smt_pkg::CAPACITY; i++) begin : g_cell
      logic [smt_pkg::KEY_BITS-1:0] upper;

      if (i == smt_pkg::CAPACITY - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = entries[i+1];
      end

      smt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .index       (smt_pkg::COUNT_BITS'(i)),
         .count       (count),
         .key         (key),
         .upper_entry (upper),
         .shift_in    (shift_chain[i]),
         .shift_out   (shift_chain[i+1]),
         .match       (match_vec[i]),
         .entry       (entries[i])
      );
   end

   // Entries are distinct, so at most one cell matches.
   assign member = |match_vec;

endmodule

@@ rtl/core/set_membership_table_top.sv @@
// Set membership table: a bounded, packed set of distinct elements with insert, delete, query.
// Each accepted request beat runs a compare pass, then an update pass in the row of cells;
// the update pass registers the response beat. A new request beat is taken only while idle
// or in an update pass that goes ahead; a waiting response holds the update pass until it is taken.
// Reset: synchronous, active high; the count clears to zero and the set is empty at once.
// Entry contents are not reset; only entries below the count are ever compared.
module set_membership_table_top (
   input  logic      clock,
   input  logic      reset,
   smt_req_if.sink   req_bus,
   smt_rsp_if.source rsp_bus
);

   // Control state.
   smt_pkg::state_type             state_ff, state_in;
   logic [smt_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Captured request.
   logic [smt_pkg::ACTION_BITS-1:0] action_ff, action_in;
   logic [smt_pkg::KEY_BITS-1:0]    key_ff, key_in;

   // Response payload.
   logic                           was_member_ff, was_member_in;
   logic [smt_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                           empty_ff, empty_in;
   logic                           full_ff, full_in;
   logic                           dropped_ff, dropped_in;

   smt_pkg::cell_ctrl_type         ctrl;
   logic                           member;
   logic [smt_pkg::CAPACITY-1:0]   match_vec;
   logic                           req_beat;
   logic                           out_free;
   logic                           is_insert, is_delete, set_full;

   smt_cell_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .count     (count_ff),
      .key       (key_ff),
      .member    (member),
      .match_vec (match_vec)
   );

   // The response register is free when empty or when its beat is being taken.
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat  = req_bus.valid && req_bus.ready;
   assign is_insert = action_ff == smt_pkg::ACT_INSERT;
   assign is_delete = action_ff == smt_pkg::ACT_DELETE;
   assign set_full  = count_ff == smt_pkg::COUNT_BITS'(smt_pkg::CAPACITY);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      action_in       = action_ff;
      key_in          = key_ff;
      was_member_in   = was_member_ff;
      rsp_count_in    = rsp_count_ff;
      empty_in        = empty_ff;
      full_in         = full_ff;
      dropped_in      = dropped_ff;
      ctrl.compare_en = 1'b0;
      ctrl.append_en  = 1'b0;
      ctrl.delete_en  = 1'b0;
      req_bus.ready   = 1'b0;

      unique case (state_ff)
         smt_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
         end
         smt_pkg::S_COMPARE: begin
            // Every active cell compares its entry with the captured key.
            ctrl.compare_en = 1'b1;
            state_in        = smt_pkg::S_UPDATE;
         end
         smt_pkg::S_UPDATE: begin
            if (out_free) begin
               // The next request may be captured in the same cycle as this update.
               req_bus.ready  = 1'b1;
               state_in       = smt_pkg::S_IDLE;
               ctrl.append_en = is_insert && !member && !set_full;
               ctrl.delete_en = is_delete && member;
               if (ctrl.append_en) begin
                  count_in = count_ff + 1'b1;
               end else if (ctrl.delete_en) begin
                  count_in = count_ff - 1'b1;
               end
               rsp_valid_in  = 1'b1;
               was_member_in = member;
               rsp_count_in  = count_in;
               empty_in      = count_in == '0;
               full_in       = count_in == smt_pkg::COUNT_BITS'(smt_pkg::CAPACITY);
               dropped_in    = is_insert && !member && set_full;
            end
         end
         default: begin
            state_in = smt_pkg::S_IDLE;
         end
      endcase

      if (req_beat) begin
         action_in = req_bus.action;
         key_in    = req_bus.element[smt_pkg::KEY_BITS-1:0];
         state_in  = smt_pkg::S_COMPARE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      was_member_ff <= was_member_in;
      rsp_count_ff  <= rsp_count_in;
      empty_ff      <= empty_in;
      full_ff       <= full_in;
      dropped_ff    <= dropped_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.was_member     = was_member_ff;
   assign rsp_bus.member_count   = rsp_count_ff;
   assign rsp_bus.is_empty       = empty_ff;
   assign rsp_bus.is_full        = full_ff;
   assign rsp_bus.insert_dropped = dropped_ff;

   // The count never passes the capacity of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smt_pkg::COUNT_BITS'(smt_pkg::CAPACITY))
      else $error("set count exceeds capacity");

   // Distinct entries mean at most one cell matches during an update.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smt_pkg::S_UPDATE) |-> ($countones(match_vec) <= 1))
      else $error("more than one cell matched the key");

   // An accepted request beat always starts a compare pass.
   a_beat_compare: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == smt_pkg::S_COMPARE))
      else $error("accepted request did not start a compare pass");

   // A dropped insert can only be reported against a full set.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> full_ff)
      else $error("insert dropped while set not full");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for set_membership_table_top: directed and random insert, delete and
// query beats, checked against a behavioural copy of the set. Depends on smt_pkg and smt_if.
`timescale 1ns / 100ps

module tb;

   // The spare action code has no member in the package enum. The block treats it as a query.
   localparam logic [smt_pkg::ACTION_BITS-1:0] ACT_SPARE = 2'd3;

   // Size of the pool that random elements are drawn from. It is larger than the capacity, so
   // the set can fill and absent elements are still offered to a full set.
   localparam int POOL_SIZE = 80;

   // Number of cycles that the receiver holds off once, to back the block up into its input.
   localparam int LONG_HOLD = 400;

   // Response count at which the long hold starts.
   localparam int HOLD_AT = 500;

   // A request waiting to be driven. When settle_first is set, the driver pauses before this
   // request until every outstanding response has come back.
   typedef struct {
      logic [smt_pkg::ACTION_BITS-1:0] action;
      logic [smt_pkg::INPUT_BITS-1:0]  element;
      bit                              settle_first;
   } set_op_type;

   // The fields of one response beat, as the predictor works them out.
   typedef struct {
      logic                           was_member;
      logic [smt_pkg::COUNT_BITS-1:0] member_count;
      logic                           is_empty;
      logic                           is_full;
      logic                           insert_dropped;
   } set_outcome_type;

   logic clock;
   logic reset;

   smt_req_if req_bus ();
   smt_rsp_if rsp_bus ();

   set_membership_table_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Requests still to be driven, and the outcomes of accepted requests still to be seen.
   set_op_type      pending_ops[$];
   set_outcome_type expected_outcomes[$];

   // The predictor's own copy of the set: packed keys in insertion order, and how many are held.
   logic [smt_pkg::KEY_BITS-1:0] held_keys[smt_pkg::CAPACITY];
   int                           held_count = 0;

   logic [smt_pkg::INPUT_BITS-1:0] element_pool[POOL_SIZE];

   int unsigned ops_accepted  = 0;
   int unsigned outcomes_seen = 0;
   int unsigned failures      = 0;

   // -------------------------------------------------------------------------------------------
   // Clock and time limit
   // -------------------------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Even the slowest correct run needs well under a fifth of this time.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------------------------

   // Applies one operation to the local copy of the set and returns the response it should give.
   // Only the low KEY_BITS bits of an element take part. Delete closes the gap it leaves by
   // moving every later key down one place, so the keys stay packed from index 0.
   function automatic set_outcome_type predict_set_op(logic [smt_pkg::ACTION_BITS-1:0] act,
                                                      logic [smt_pkg::INPUT_BITS-1:0]  elem);
      logic [smt_pkg::KEY_BITS-1:0] key;
      int                           hit;
      set_outcome_type              res;
      key = elem[smt_pkg::KEY_BITS-1:0];
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == key) begin
            hit = i;
         end
      end
      res.was_member     = (hit >= 0);
      res.insert_dropped = 1'b0;
      if (act == smt_pkg::ACT_INSERT) begin
         if (hit < 0) begin
            if (held_count < smt_pkg::CAPACITY) begin
               held_keys[held_count] = key;
               held_count++;
            end else begin
               res.insert_dropped = 1'b1;
            end
         end
      end else if (act == smt_pkg::ACT_DELETE) begin
         if (hit >= 0) begin
            for (int j = hit; j < held_count - 1; j++) begin
               held_keys[j] = held_keys[j + 1];
            end
            held_count--;
         end
      end
      // Query, and the spare code, leave the set untouched.
      res.member_count = smt_pkg::COUNT_BITS'(held_count);
      res.is_empty     = (held_count == 0);
      res.is_full      = (held_count == smt_pkg::CAPACITY);
      return res;
   endfunction

   // Idle cycles between beats: mostly a random count, with one stretch in every four where the
   // side does not idle at all.
   function automatic int unsigned idle_draw(int unsigned beats);
      if (((beats / 160) % 4) == 2) begin
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch on response %0d: expected %0d, got %0d",
                name, outcomes_seen, want, got);
         failures++;
      end
   endfunction

   task automatic add_op(logic [smt_pkg::ACTION_BITS-1:0] act,
                         logic [smt_pkg::INPUT_BITS-1:0] elem, bit settle = 1'b0);
      set_op_type op;
      op.action       = act;
      op.element      = elem;
      op.settle_first = settle;
      pending_ops.push_back(op);
   endtask

   // -------------------------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------------------------

   // A beat is accepted at an edge where valid and ready are both high. The outcome of each
   // accepted beat is predicted there and then, so the expectations are queued in the order that
   // the block takes the requests. After each beat the driver idles for its drawn gap.
   int unsigned req_gap;

   always @(posedge clock) begin : request_driver
      set_op_type next_op;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.action  <= smt_pkg::ACT_QUERY;
         req_bus.element <= '0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_outcomes.push_back(predict_set_op(req_bus.action, req_bus.element));
            ops_accepted++;
         end
         // A beat that has been offered stays on the bus until it is taken.
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].settle_first && expected_outcomes.size() != 0)) begin
               next_op = pending_ops.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.action  <= next_op.action;
               req_bus.element <= next_op.element;
               req_gap = idle_draw(ops_accepted);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------------------------
   // Response monitor
   // -------------------------------------------------------------------------------------------

   // Each response beat is compared with the oldest expectation. After each beat the receiver
   // stalls for its drawn count. Once, part way through the run, it also holds off for a long
   // stretch while the driver keeps offering requests, so the block fills and stalls its input.
   int unsigned rsp_wait;
   int unsigned rsp_hold;
   bit          hold_done;

   // The long hold is counted down in a process of its own.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         rsp_hold  <= 0;
         hold_done <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!hold_done && outcomes_seen >= HOLD_AT) begin
         rsp_hold  <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : response_monitor
      set_outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            outcomes_seen++;
            if (expected_outcomes.size() == 0) begin
               $error("response beat %0d arrived with no request outstanding", outcomes_seen);
               failures++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("was_member", 32'(want.was_member), 32'(rsp_bus.was_member));
               check_field("member_count", 32'(want.member_count),
                           32'(rsp_bus.member_count));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_bus.is_empty));
               check_field("is_full", 32'(want.is_full), 32'(rsp_bus.is_full));
               check_field("insert_dropped", 32'(want.insert_dropped),
                           32'(rsp_bus.insert_dropped));
            end
            rsp_wait = idle_draw(outcomes_seen);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_bus.ready <= (rsp_wait == 0 && rsp_hold == 0);
      end
   end

   // -------------------------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------------------------

   initial begin : stimulus
      int                             kind;
      int unsigned                    roll;
      bit                             fresh;
      logic [smt_pkg::INPUT_BITS-1:0] pick;

      reset = 1'b1;

      // Directed part. The set starts empty, so query and delete on an empty set come first.
      // Then the extreme element values go in, a present element is inserted again, the spare
      // action code is used as a query, an absent element is deleted, and deletes from the
      // middle, the front and the back of the set check that the keys are moved down correctly.
      // Finally the set is emptied again by deletes.
      add_op(smt_pkg::ACT_QUERY,  32'h0000_0000);
      add_op(smt_pkg::ACT_DELETE, 32'h0000_0005);
      add_op(smt_pkg::ACT_INSERT, 32'h0000_0000);
      add_op(smt_pkg::ACT_INSERT, 32'hFFFF_FFFF);
      add_op(smt_pkg::ACT_INSERT, 32'h0000_0000);
      add_op(smt_pkg::ACT_QUERY,  32'hFFFF_FFFF);
      add_op(ACT_SPARE,           32'hFFFF_FFFF);
      add_op(smt_pkg::ACT_INSERT, 32'h8000_0000);
      add_op(smt_pkg::ACT_INSERT, 32'h0000_0001);
      add_op(smt_pkg::ACT_INSERT, 32'h5555_5555);
      add_op(smt_pkg::ACT_DELETE, 32'hAAAA_AAAA);
      add_op(smt_pkg::ACT_DELETE, 32'hFFFF_FFFF);
      add_op(smt_pkg::ACT_QUERY,  32'h8000_0000);
      add_op(smt_pkg::ACT_DELETE, 32'h0000_0000);
      add_op(smt_pkg::ACT_DELETE, 32'h5555_5555);
      add_op(smt_pkg::ACT_INSERT, 32'hAAAA_AAAA);
      add_op(ACT_SPARE,           32'hAAAA_AAAA);
      add_op(smt_pkg::ACT_QUERY,  32'h0000_0001);
      add_op(smt_pkg::ACT_DELETE, 32'h8000_0000);
      add_op(smt_pkg::ACT_DELETE, 32'h0000_0001);
      add_op(smt_pkg::ACT_DELETE, 32'hAAAA_AAAA);
      add_op(smt_pkg::ACT_QUERY,  32'hAAAA_AAAA);

      // A pool of distinct random elements, so that inserts, deletes and queries hit members
      // often and the set can be filled to capacity.
      for (int p = 0; p < POOL_SIZE; p++) begin
         do begin
            pick  = $urandom;
            fresh = 1'b1;
            for (int q = 0; q < p; q++) begin
               if (element_pool[q] == pick) begin
                  fresh = 1'b0;
               end
            end
         end while (!fresh);
         element_pool[p] = pick;
      end

      // Random part in segments of 150 beats. The kind of segment cycles through a pure fill
      // (which reaches capacity and then offers absent elements to the full set), a mixed
      // segment, a draining segment and a fill-biased one. A few beats in each segment but the
      // pure fill are noise: any action code with a fully random element. At the start of some
      // segments the driver waits for every outstanding response.
      for (int seg = 0; seg < 13; seg++) begin
         kind = seg % 4;
         for (int n = 0; n < 150; n++) begin
            roll = $urandom_range(0, 99);
            pick = element_pool[$urandom_range(0, POOL_SIZE - 1)];
            fresh = (n == 0) && (seg % 3 == 2);
            if (kind != 0 && roll < 8) begin
               add_op(smt_pkg::ACTION_BITS'($urandom_range(0, 3)), $urandom, fresh);
            end else begin
               roll = $urandom_range(0, 99);
               case (kind)
                  0: add_op(smt_pkg::ACT_INSERT, pick, fresh);
                  1: begin
                     if (roll < 40)      add_op(smt_pkg::ACT_INSERT, pick, fresh);
                     else if (roll < 70) add_op(smt_pkg::ACT_DELETE, pick, fresh);
                     else                add_op(smt_pkg::ACT_QUERY, pick, fresh);
                  end
                  2: begin
                     if (roll < 70)      add_op(smt_pkg::ACT_DELETE, pick, fresh);
                     else if (roll < 85) add_op(smt_pkg::ACT_INSERT, pick, fresh);
                     else                add_op(smt_pkg::ACT_QUERY, pick, fresh);
                  end
                  default: begin
                     if (roll < 70)      add_op(smt_pkg::ACT_INSERT, pick, fresh);
                     else if (roll < 85) add_op(smt_pkg::ACT_DELETE, pick, fresh);
                     else                add_op(smt_pkg::ACT_QUERY, pick, fresh);
                  end
               endcase
            end
         end
      end

      // Reset is held from the start and released at a clock edge.
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request has been taken and every response has come back, then let a
      // few more cycles pass so that any stray response beat is caught by the monitor.
      while (pending_ops.size() != 0 || req_bus.valid || expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
